// ----- rtl/core/glk_pkg.sv -----
package glk_pkg;

  localparam int SlotW = 6;

  typedef struct packed {
    logic        with_edge;
    logic [7:0]  pixel_size;
    logic [7:0]  font_id;
    logic [20:0] code_point;
  } glk_req_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    logic             evicted;
    logic [20:0]      old_code_point;
    logic [7:0]       old_font_id;
    logic [7:0]       old_pixel_size;
    logic             old_with_edge;
  } glk_rsp_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } glk_res_t;

endpackage

// ----- rtl/core/glk_cam.sv -----
module glk_cam import glk_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  glk_req_t         key,
  input  logic             wr_en,
  input  logic [SLOTS-1:0] wr_oh,
  input  logic [SLOTS-1:0] rd_oh,
  output logic [SLOTS-1:0] valid_vec,
  output logic [SLOTS-1:0] match_vec,
  output glk_req_t         rd_key
);

  localparam int KeyW = $bits(glk_req_t);

  glk_req_t         keys_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  logic [KeyW-1:0]  rd_acc;

  // an entry only becomes valid; eviction rewrites it in place
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt = valid_r | wr_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (wr_en && wr_oh[i]) begin
        keys_r[i] <= key;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = valid_r[i] && (keys_r[i] == key);
    end
  end

  // one-hot and-or read of the victim key
  always_comb begin
    rd_acc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rd_oh[i]) begin
        rd_acc = rd_acc | keys_r[i];
      end
    end
  end

  assign rd_key    = rd_acc;
  assign valid_vec = valid_r;

endmodule

// ----- rtl/core/glk_rank.sv -----
module glk_rank import glk_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [SLOTS-1:0]         valid_vec,
  input  logic [SLOTS-1:0]         match_vec,
  output glk_res_t                 res,
  output logic [SLOTS-1:0]         slot_oh,
  output logic [$clog2(SLOTS)-1:0] slot_idx
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [SW-1:0]    rank_r   [SLOTS];
  logic [SW-1:0]    rank_nxt [SLOTS];
  logic [CW-1:0]    fill_r;
  logic [CW-1:0]    fill_nxt;
  logic             hit;
  logic             full;
  logic [SW-1:0]    hit_rank;
  logic [SLOTS-1:0] victim_raw;
  logic [SLOTS-1:0] free_oh;

  assign hit  = |match_vec;
  assign full = (fill_r == CW'(SLOTS));

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match_vec[i]) begin
        hit_rank = hit_rank | rank_r[i];
      end
    end
  end

  // ranks of valid slots are a permutation, so only one holds the oldest rank
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      victim_raw[i] = valid_vec[i] && (rank_r[i] == SW'(SLOTS - 1));
      free_oh[i]    = (fill_r[SW-1:0] == SW'(i));
    end
  end

  assign slot_oh = hit ? match_vec : (full ? victim_raw : free_oh);

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_oh[i]) begin
        slot_idx = slot_idx | SW'(i);
      end
    end
  end

  assign res.hit   = hit;
  assign res.evict = !hit && full;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
      if (go) begin
        if (slot_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_vec[i] && (!hit || rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
    fill_nxt = fill_r;
    if (go && !hit && !full) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec)) else $error("key matches more than one slot");

  a_victim_unique: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> $onehot(victim_raw)) else $error("full cache without a single lru victim");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(SLOTS)) else $error("fill count beyond slot count");

  a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !hit && !full) |=> (fill_r == CW'($past(fill_r) + 1'b1)))
    else $error("fill count did not advance on a miss into a free slot");
`endif

endmodule

// ----- rtl/core/glyph_key_lru_cache.sv -----
// pipeline: an item accepted into the request register has its result registered in the result
//   register and can transfer from there; a stalled result holds the item in the request stage
// throughput: one item per cycle unless the result stage stalls; tag compare, victim pick and rank
//   update of all slots are combinational between the request and result registers
// reset (rst_n low, synchronous): both stages empty, all slots invalid, ranks and
//   fill count zero; stored keys are not cleared
module glyph_key_lru_cache import glk_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  glk_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output glk_rsp_t out_rsp
);

  localparam int SW = $clog2(SLOTS);

  logic             in_valid_r;
  glk_req_t         in_req_r;
  logic             out_valid_r;
  glk_rsp_t         out_rsp_r;
  glk_rsp_t         out_rsp_nxt;
  logic             adv;
  logic             go;
  logic [SLOTS-1:0] valid_vec;
  logic [SLOTS-1:0] match_vec;
  logic [SLOTS-1:0] slot_oh;
  logic [SW-1:0]    slot_idx;
  logic [SW+5:0]    slot_ext;
  glk_req_t         old_key;
  glk_res_t         res;

  // result stage can take a new item when empty or when its item transfers
  assign adv      = !out_valid_r || !out_stall;
  assign go       = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  glk_cam #(.SLOTS(SLOTS)) u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (in_req_r),
    .wr_en     (go && !res.hit),
    .wr_oh     (slot_oh),
    .rd_oh     (slot_oh),
    .valid_vec (valid_vec),
    .match_vec (match_vec),
    .rd_key    (old_key)
  );

  glk_rank #(.SLOTS(SLOTS)) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .valid_vec (valid_vec),
    .match_vec (match_vec),
    .res       (res),
    .slot_oh   (slot_oh),
    .slot_idx  (slot_idx)
  );

  assign slot_ext = (SW + 6)'(slot_idx);

  always_comb begin
    out_rsp_nxt                = '0;
    out_rsp_nxt.hit            = res.hit;
    out_rsp_nxt.slot           = slot_ext[SlotW-1:0];
    out_rsp_nxt.evicted        = res.evict;
    if (res.evict) begin
      out_rsp_nxt.old_code_point = old_key.code_point;
      out_rsp_nxt.old_font_id    = old_key.font_id;
      out_rsp_nxt.old_pixel_size = old_key.pixel_size;
      out_rsp_nxt.old_with_edge  = old_key.with_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_req;
    end
    if (go) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- sim/glyph_key_lru_cache_test.sv -----
module glyph_key_lru_cache_test;
  import glk_pkg::*;

  localparam int SLOTS       = 64;
  localparam int POOL        = 96;
  localparam int RAND_ITEMS  = 1550;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 8;

  typedef enum {
    MIX_HOT,
    MIX_THRASH,
    MIX_SCAN,
    MIX_NOISE
  } traffic_t;

  typedef struct {
    glk_req_t req;
    bit       typed;
    glk_rsp_t rsp;
  } glyph_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  glk_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  glk_rsp_t out_rsp;

  // mirror of the tag store
  logic [37:0] tag_key [SLOTS];
  bit          tag_live [SLOTS];
  int unsigned tag_age [SLOTS];
  int unsigned used_slots;

  glk_rsp_t   expected_rsp [$];
  glyph_row_t glyph_rows [$];
  glk_req_t   key_pool [$];
  int         errors;
  int         cycles;
  bit         calm;
  int         stall_left;

  glyph_key_lru_cache #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  always #10 clk = ~clk;

  function automatic glk_req_t mk_req(logic [20:0] cp, logic [7:0] font, logic [7:0] size,
                                      logic edge_bit);
    glk_req_t r;
    r.code_point = cp;
    r.font_id    = font;
    r.pixel_size = size;
    r.with_edge  = edge_bit;
    return r;
  endfunction

  function automatic glk_rsp_t mk_rsp(logic hit, logic [5:0] slot);
    glk_rsp_t r;
    r      = '0;
    r.hit  = hit;
    r.slot = slot;
    return r;
  endfunction

  function automatic glk_req_t rand_key();
    logic [31:0] a;
    logic [31:0] b;
    glk_req_t    r;
    a = $urandom();
    b = $urandom();
    r.code_point = a[20:0];
    r.font_id    = b[7:0];
    r.pixel_size = b[15:8];
    r.with_edge  = b[16];
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // fully associative lookup with plain lru replacement
  function automatic glk_rsp_t lookup_glyph(glk_req_t r);
    glk_rsp_t    rsp;
    logic [37:0] key;
    int          s;
    int unsigned oldest;
    rsp = '0;
    key = r;
    s   = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && tag_live[i] && tag_key[i] == key) s = i;
    if (s >= 0) begin
      rsp.hit = 1'b1;
      for (int i = 0; i < SLOTS; i++)
        if (tag_live[i] && tag_age[i] < tag_age[s]) tag_age[i]++;
      tag_age[s] = 0;
    end else begin
      if (used_slots < SLOTS) begin
        s = used_slots;
        used_slots++;
      end else begin
        // oldest entry, lowest slot on a tie
        oldest = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tag_live[i] && (s < 0 || tag_age[i] > oldest)) begin
            oldest = tag_age[i];
            s      = i;
          end
        rsp.evicted = 1'b1;
        {rsp.old_with_edge, rsp.old_pixel_size, rsp.old_font_id, rsp.old_code_point} =
          tag_key[s];
        tag_live[s] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++)
        if (tag_live[i]) tag_age[i]++;
      tag_key[s]  = key;
      tag_live[s] = 1'b1;
      tag_age[s]  = 0;
    end
    rsp.slot = s[5:0];
    return rsp;
  endfunction

  task automatic add_row(glk_req_t req, bit typed, glk_rsp_t rsp);
    glyph_row_t row;
    row.req   = req;
    row.typed = typed;
    row.rsp   = rsp;
    glyph_rows.push_back(row);
  endtask

  // called at a rising edge; returns at the edge of the transfer, or after the idle gap that follows it
  task automatic send_glyph(glk_req_t r, bit typed, glk_rsp_t typed_rsp, bit park);
    glk_rsp_t predicted;
    int       gap;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(negedge clk); while (in_stall);
    predicted = lookup_glyph(r);
    expected_rsp.push_back(typed ? typed_rsp : predicted);
    @(posedge clk);
    gap = calm ? 0 : gap_len();
    if (park && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: decide at the falling edge, transfer lands on the next rising edge
  always @(negedge clk) begin
    glk_rsp_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("hit", want.hit, out_rsp.hit);
        check_field("slot", want.slot, out_rsp.slot);
        check_field("evicted", want.evicted, out_rsp.evicted);
        check_field("old_code_point", want.old_code_point, out_rsp.old_code_point);
        check_field("old_font_id", want.old_font_id, out_rsp.old_font_id);
        check_field("old_pixel_size", want.old_pixel_size, out_rsp.old_pixel_size);
        check_field("old_with_edge", want.old_with_edge, out_rsp.old_with_edge);
      end
    end
  end

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm) stall_left = gap_len();
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** glyph_key_lru_cache: FAILED **");
    $finish;
  end

  initial begin
    traffic_t mode;
    int       phase_left;
    int       hot_n;
    int       scan_pos;
    int       idx;
    bit       park;
    glk_req_t r;

    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    errors     = 0;
    calm       = 1'b0;
    used_slots = 0;
    phase_left = 0;
    hot_n      = 8;
    scan_pos   = 0;
    mode       = MIX_HOT;
    for (int i = 0; i < SLOTS; i++) begin
      tag_key[i]  = '0;
      tag_live[i] = 1'b0;
      tag_age[i]  = 0;
    end

    // empty cache after reset, field extremes, single-bit key differences
    add_row(mk_req(21'h0, 8'h00, 8'h00, 1'b0), 1, mk_rsp(1'b0, 6'd0));
    add_row(mk_req(21'h0, 8'h00, 8'h00, 1'b0), 1, mk_rsp(1'b1, 6'd0));
    add_row(mk_req(21'h1FFFFF, 8'hFF, 8'hFF, 1'b1), 1, mk_rsp(1'b0, 6'd1));
    add_row(mk_req(21'h10FFFF, 8'hFF, 8'hFF, 1'b1), 1, mk_rsp(1'b0, 6'd2));
    add_row(mk_req(21'h1FFFFF, 8'hFF, 8'hFF, 1'b0), 1, mk_rsp(1'b0, 6'd3));
    add_row(mk_req(21'h1FFFFF, 8'hFF, 8'hFF, 1'b1), 1, mk_rsp(1'b1, 6'd1));
    add_row(mk_req(21'h0, 8'h00, 8'h00, 1'b1), 1, mk_rsp(1'b0, 6'd4));
    add_row(mk_req(21'h0, 8'h01, 8'h00, 1'b0), 1, mk_rsp(1'b0, 6'd5));
    add_row(mk_req(21'h0, 8'h00, 8'h01, 1'b0), 1, mk_rsp(1'b0, 6'd6));
    add_row(mk_req(21'h1, 8'h00, 8'h00, 1'b0), 1, mk_rsp(1'b0, 6'd7));
    add_row(mk_req(21'h0, 8'h00, 8'h00, 1'b0), 1, mk_rsp(1'b1, 6'd0));
    add_row(mk_req(21'h10FFFF, 8'hFF, 8'hFF, 1'b1), 1, mk_rsp(1'b1, 6'd2));
    add_row(mk_req(21'h000041, 8'd7, 8'd16, 1'b0), 0, '0);
    add_row(mk_req(21'h000041, 8'd7, 8'd16, 1'b1), 0, '0);
    add_row(mk_req(21'h000041, 8'd7, 8'd17, 1'b0), 0, '0);
    add_row(mk_req(21'h000041, 8'd8, 8'd16, 1'b0), 0, '0);
    add_row(mk_req(21'h000041, 8'd7, 8'd16, 1'b0), 0, '0);
    add_row(mk_req(21'h01F600, 8'd3, 8'd48, 1'b1), 0, '0);
    add_row(mk_req(21'h004E2D, 8'd200, 8'd12, 1'b0), 0, '0);
    add_row(mk_req(21'h01F600, 8'd3, 8'd48, 1'b1), 0, '0);
    add_row(mk_req(21'h155555, 8'hAA, 8'h55, 1'b1), 0, '0);
    add_row(mk_req(21'h0AAAAA, 8'h55, 8'hAA, 1'b0), 0, '0);
    add_row(mk_req(21'h000041, 8'd7, 8'd17, 1'b0), 0, '0);

    for (int i = 0; i < POOL; i++) key_pool.push_back(rand_key());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (glyph_rows[i])
      send_glyph(glyph_rows[i].req, glyph_rows[i].typed, glyph_rows[i].rsp, 1'b0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode       = traffic_t'($urandom_range(0, 3));
        phase_left = $urandom_range(40, 200);
        calm       = ($urandom_range(0, 3) == 0);
        hot_n      = $urandom_range(4, SLOTS);
        scan_pos   = $urandom_range(0, POOL - 1);
      end
      phase_left--;
      case (mode)
        MIX_HOT: begin
          r = key_pool[$urandom_range(0, hot_n - 1)];
        end
        MIX_THRASH: begin
          r = key_pool[$urandom_range(0, POOL - 1)];
        end
        MIX_SCAN: begin
          // cycling more keys than slots evicts in strict lru order
          scan_pos = (scan_pos + 1) % POOL;
          r = key_pool[scan_pos];
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            r = rand_key();
          end else begin
            idx = $urandom_range(0, POOL - 1);
            r = key_pool[idx] ^ (38'd1 << $urandom_range(0, 37));
          end
        end
      endcase
      park = (n == RAND_ITEMS / 2) || (n == RAND_ITEMS - 1);
      send_glyph(r, 1'b0, '0, park);
      if (n == RAND_ITEMS / 2)
        while (expected_rsp.size() != 0) @(posedge clk);
    end

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("** glyph_key_lru_cache: PASSED **");
    end else begin
      $display("** glyph_key_lru_cache: FAILED **");
    end
    $finish;
  end

endmodule

// ----- glyph_key_lru_cache.f -----
rtl/core/glk_pkg.sv
rtl/core/glk_cam.sv
rtl/core/glk_rank.sv
rtl/core/glyph_key_lru_cache.sv
sim/glyph_key_lru_cache_test.sv
